/* hw/rtl/satd_hadamard4x4_32x8_top_assert.svh */
// Assertion helpers for the SATD top level.
// Both expect clk and arst_n in scope.
`ifndef SATD_HADAMARD4X4_32X8_TOP_ASSERT_SVH
`define SATD_HADAMARD4X4_32X8_TOP_ASSERT_SVH

// Same-cycle implication
`define SATDH_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error(msg);

// Next-cycle implication
`define SATDH_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error(msg);

`endif

/* hw/rtl/satdh_pkg.sv */
`default_nettype none
package satdh_pkg;

	// Block geometry defaults
	localparam int BLOCK_WIDTH_DEF     = 32;
	localparam int BLOCK_HEIGHT_DEF    = 8;
	localparam int PIXELS_PER_ITEM_DEF = 8;

	// Field and datapath widths
	localparam int PIX_W       = 8;
	localparam int IN_LANES    = 8;
	localparam int PIX_IN_W    = PIX_W * IN_LANES;
	localparam int COEF_W      = 12;
	localparam int TERM_W      = 14;
	localparam int SUM_W       = 20;
	localparam int SATD_W      = 19;
	localparam int TDATA_IN_W  = 2 * PIX_IN_W;
	localparam int TDATA_OUT_W = 24;

	// Row position within a quad of rows
	typedef logic [1:0] phase_t;
	localparam phase_t PHASE_CHECK = 2'd3;

	// Row store write request
	typedef struct packed {
		logic   en;
		phase_t row;
	} st_wr_t;

endpackage
`default_nettype wire

/* hw/rtl/satdh_row_xform.sv */
`default_nettype none
module satdh_row_xform
	import satdh_pkg::*;
#(
	parameter int NL = 8
) (
	input  wire logic [PIX_IN_W-1:0]  pix_a,
	input  wire logic [PIX_IN_W-1:0]  pix_b,
	output logic      [NL*COEF_W-1:0] coef
);

	localparam int D_W = PIX_W + 1;
	localparam int S_W = D_W + 1;
	localparam int H_W = S_W + 1;

	logic signed [D_W-1:0] x [NL];

	// Pixel differences; lanes past the input width count as zero
	for (genvar l = 0; l < NL; l++) begin : g_diff
		if (l < IN_LANES) begin : g_px
			assign x[l] = $signed({1'b0, pix_a[PIX_W*l +: PIX_W]})
				- $signed({1'b0, pix_b[PIX_W*l +: PIX_W]});
		end else begin : g_zero
			assign x[l] = '0;
		end
	end

	// 4-point Hadamard over each group of four differences
	for (genvar g = 0; g < NL / 4; g++) begin : g_grp
		logic signed [S_W-1:0] s01, d01, s23, d23;
		logic signed [H_W-1:0] h0, h1, h2, h3;

		assign s01 = S_W'(x[4*g+0]) + S_W'(x[4*g+1]);
		assign d01 = S_W'(x[4*g+1]) - S_W'(x[4*g+0]);
		assign s23 = S_W'(x[4*g+2]) + S_W'(x[4*g+3]);
		assign d23 = S_W'(x[4*g+3]) - S_W'(x[4*g+2]);
		assign h0  = H_W'(s01) + H_W'(s23);
		assign h1  = H_W'(s23) - H_W'(s01);
		assign h2  = H_W'(d01) + H_W'(d23);
		assign h3  = H_W'(d23) - H_W'(d01);

		assign coef[COEF_W*(4*g+0) +: COEF_W] = COEF_W'(h0);
		assign coef[COEF_W*(4*g+1) +: COEF_W] = COEF_W'(h1);
		assign coef[COEF_W*(4*g+2) +: COEF_W] = COEF_W'(h2);
		assign coef[COEF_W*(4*g+3) +: COEF_W] = COEF_W'(h3);
	end

endmodule
`default_nettype wire

/* hw/rtl/satdh_row_store.sv */
`default_nettype none
module satdh_row_store
	import satdh_pkg::*;
#(
	parameter int DEPTH  = 4,
	parameter int ADDR_W = 2,
	parameter int WORD_W = 96
) (
	input  wire logic              clk,
	input  wire st_wr_t            wr,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WORD_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WORD_W-1:0] rd_r0,
	output logic      [WORD_W-1:0] rd_r1,
	output logic      [WORD_W-1:0] rd_r2
);

	// One word per item position, one array per held row of the quad
	logic [WORD_W-1:0] mem0 [DEPTH];
	logic [WORD_W-1:0] mem1 [DEPTH];
	logic [WORD_W-1:0] mem2 [DEPTH];

	// Write the transformed row into its slot
	always_ff @(posedge clk) begin
		if (wr.en) begin
			case (wr.row)
				2'd0:    mem0[wr_addr] <= wr_data;
				2'd1:    mem1[wr_addr] <= wr_data;
				2'd2:    mem2[wr_addr] <= wr_data;
				default: ;
			endcase
		end
	end

	// Registered read of all three held rows at one position
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_r0 <= mem0[rd_addr];
			rd_r1 <= mem1[rd_addr];
			rd_r2 <= mem2[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/satdh_col_term.sv */
`default_nettype none
module satdh_col_term
	import satdh_pkg::*;
#(
	parameter int NL = 8
) (
	input  wire logic [NL*COEF_W-1:0] r0,
	input  wire logic [NL*COEF_W-1:0] r1,
	input  wire logic [NL*COEF_W-1:0] r2,
	input  wire logic [NL*COEF_W-1:0] r3,
	output logic      [NL*TERM_W-1:0] term
);

	localparam int P_W = COEF_W + 1;

	// Column butterfly with max of magnitudes, per lane
	for (genvar l = 0; l < NL; l++) begin : g_lane
		logic signed [P_W-1:0] s01, d01, s23, d23;
		logic        [P_W-1:0] as01, ad01, as23, ad23, m0, m1;

		assign s01 = P_W'($signed(r0[COEF_W*l +: COEF_W]))
			+ P_W'($signed(r1[COEF_W*l +: COEF_W]));
		assign d01 = P_W'($signed(r0[COEF_W*l +: COEF_W]))
			- P_W'($signed(r1[COEF_W*l +: COEF_W]));
		assign s23 = P_W'($signed(r2[COEF_W*l +: COEF_W]))
			+ P_W'($signed(r3[COEF_W*l +: COEF_W]));
		assign d23 = P_W'($signed(r2[COEF_W*l +: COEF_W]))
			- P_W'($signed(r3[COEF_W*l +: COEF_W]));

		assign as01 = s01[P_W-1] ? P_W'(-s01) : P_W'(s01);
		assign ad01 = d01[P_W-1] ? P_W'(-d01) : P_W'(d01);
		assign as23 = s23[P_W-1] ? P_W'(-s23) : P_W'(s23);
		assign ad23 = d23[P_W-1] ? P_W'(-d23) : P_W'(d23);

		assign m0 = (as01 > as23) ? as01 : as23;
		assign m1 = (ad01 > ad23) ? ad01 : ad23;

		assign term[TERM_W*l +: TERM_W] = TERM_W'(m0) + TERM_W'(m1);
	end

endmodule
`default_nettype wire

/* hw/rtl/satd_hadamard4x4_32x8_top.sv */
// Half-SATD over a block of pixel rows with 4x4 Hadamard transforms.
// Throughput: one request per cycle unless a pending result stalls; one result per block.
// The result is registered once the block's last request has passed the sum stage.
// A pending result does not stall input until the next block end reaches the sum stage.
// Reset clears pipeline valids, position counters and the running sum; store is unreset.
`default_nettype none
`include "satd_hadamard4x4_32x8_top_assert.svh"
module satd_hadamard4x4_32x8_top
	import satdh_pkg::*;
#(
	parameter int BLOCK_WIDTH     = BLOCK_WIDTH_DEF,
	parameter int BLOCK_HEIGHT    = BLOCK_HEIGHT_DEF,
	parameter int PIXELS_PER_ITEM = PIXELS_PER_ITEM_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,  // pix_a[63:0], pix_b[127:64]
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic      [TDATA_OUT_W-1:0] m_axis_tdata   // satd[18:0], zero pad
);

	localparam int NL     = (PIXELS_PER_ITEM / 4) * 4;
	localparam int IPR    = BLOCK_WIDTH / PIXELS_PER_ITEM;
	localparam int CW     = (IPR > 1) ? $clog2(IPR) : 1;
	localparam int RW     = $clog2(BLOCK_HEIGHT);
	localparam int WORD_W = NL * COEF_W;
	localparam int LSUM_W = TERM_W + $clog2(NL);

	// Handshake
	logic s_fire, rdy1, rdy2, rdy3, fire1, fire2, fire3;

	// Position in block
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          pos_last;

	// Stage 1
	logic                v_s1;
	logic [PIX_IN_W-1:0] pix_a_s1, pix_b_s1;
	logic [CW-1:0]       col_s1;
	phase_t              phase_s1;
	logic                last_s1;
	logic [WORD_W-1:0]   coef;
	st_wr_t              st_wr;

	// Stage 2
	logic              v_s2, check_s2, last_s2;
	logic [WORD_W-1:0] r0_s2, r1_s2, r2_s2, r3_s2;
	logic [NL*TERM_W-1:0] term;

	// Stage 3
	logic                 v_s3, last_s3;
	logic [NL*TERM_W-1:0] term_s3;
	logic [LSUM_W-1:0]    lane_sum;
	logic [SUM_W-1:0]     block_sum_q, sum_next;

	// Result
	logic              out_valid_q;
	logic [SATD_W-1:0] satd_q;

	// Stall only when a block result meets a pending one
	assign fire3         = v_s3 && (!last_s3 || !out_valid_q || m_axis_tready);
	assign rdy3          = !v_s3 || fire3;
	assign rdy2          = !v_s2 || rdy3;
	assign fire2         = v_s2 && rdy3;
	assign rdy1          = !v_s1 || rdy2;
	assign fire1         = v_s1 && rdy2;
	assign s_axis_tready = rdy1;
	assign s_fire        = s_axis_tvalid && rdy1;

	assign pos_last = (col_q == CW'(IPR - 1)) && (row_q == RW'(BLOCK_HEIGHT - 1));

	// Advance the item position on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (s_fire) begin
			if (pos_last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_q == CW'(IPR - 1)) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			pix_a_s1 <= s_axis_tdata[PIX_IN_W-1:0];
			pix_b_s1 <= s_axis_tdata[TDATA_IN_W-1:PIX_IN_W];
			col_s1   <= col_q;
			phase_s1 <= phase_t'(row_q[1:0]);
			last_s1  <= pos_last;
		end
	end

	satdh_row_xform #(
		.NL(NL)
	) u_row_xform (
		.pix_a(pix_a_s1),
		.pix_b(pix_b_s1),
		.coef (coef)
	);

	// Hold the first three rows of each quad
	assign st_wr.en  = fire1 && (phase_s1 != PHASE_CHECK);
	assign st_wr.row = phase_s1;

	satdh_row_store #(
		.DEPTH (IPR),
		.ADDR_W(CW),
		.WORD_W(WORD_W)
	) u_row_store (
		.clk    (clk),
		.wr     (st_wr),
		.wr_addr(col_s1),
		.wr_data(coef),
		.rd_en  (fire1),
		.rd_addr(col_s1),
		.rd_r0  (r0_s2),
		.rd_r1  (r1_s2),
		.rd_r2  (r2_s2)
	);

	// Stage 2 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			r3_s2    <= coef;
			check_s2 <= (phase_s1 == PHASE_CHECK);
			last_s2  <= last_s1;
		end
	end

	satdh_col_term #(
		.NL(NL)
	) u_col_term (
		.r0  (r0_s2),
		.r1  (r1_s2),
		.r2  (r2_s2),
		.r3  (r3_s2),
		.term(term)
	);

	// Stage 3 capture; drop terms of rows that are not a quad's last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fire2) begin
			term_s3 <= check_s2 ? term : '0;
			last_s3 <= last_s2;
		end
	end

	// Add up lane terms
	always_comb begin
		lane_sum = '0;
		for (int l = 0; l < NL; l++) begin
			lane_sum = lane_sum + LSUM_W'(term_s3[TERM_W*l +: TERM_W]);
		end
	end

	assign sum_next = block_sum_q + SUM_W'(lane_sum);

	// Accumulate; emit and restart at block end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire3) begin
				block_sum_q <= last_s3 ? '0 : sum_next;
			end
			if (fire3 && last_s3) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire3 && last_s3) begin
			satd_q <= sum_next[SATD_W-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(TDATA_OUT_W - SATD_W){1'b0}}, satd_q};

	`SATDH_ASSERT_NXT(a_emit_valid, fire3 && last_s3, m_axis_tvalid, "block result not presented")
	`SATDH_ASSERT_NXT(a_sum_restart, fire3 && last_s3, block_sum_q == '0, "block sum not cleared")
	`SATDH_ASSERT_NXT(a_pos_wrap, s_fire && pos_last, col_q == '0 && row_q == '0, "position did not wrap")
	`SATDH_ASSERT_IMP(a_no_overrun, v_s3 && last_s3 && out_valid_q && !m_axis_tready, !fire3, "pending result overrun")

endmodule
`default_nettype wire

/* sim/tb.sv */
module tb;
	import satdh_pkg::*;

	localparam int ITEMS_PER_ROW   = BLOCK_WIDTH_DEF / PIXELS_PER_ITEM_DEF;
	localparam int ITEMS_PER_BLOCK = ITEMS_PER_ROW * BLOCK_HEIGHT_DEF;
	localparam int RANDOM_BLOCKS   = 51;
	localparam int PAUSE_BLOCK     = 20;
	localparam int DRAIN_CYCLES    = 8;
	localparam int CYCLE_LIMIT     = 100000;

	typedef enum int {PIX_RANDOM, PIX_NEAR, PIX_EXTREME} pix_style_t;

	// One directed block: the same pixel row pair in every request, swapped on odd rows if swap_odd_rows is set
	typedef struct packed {
		logic [PIX_IN_W-1:0] a;
		logic [PIX_IN_W-1:0] b;
		logic                swap_odd_rows;
		logic                known;
		logic [SATD_W-1:0]   satd;
	} block_pattern_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [TDATA_IN_W-1:0]  s_axis_tdata;   // pix_a[63:0], pix_b[127:64]
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;   // satd[18:0], zero pad

	// Predictor state
	logic signed [COEF_W-1:0] quad_rows [3*BLOCK_WIDTH_DEF];
	logic [SUM_W-1:0]         half_satd_sum;
	int                       item_pos;

	logic [SATD_W-1:0] satd_due [$];
	int                errors = 0;
	int                cycles = 0;

	block_pattern_t block_patterns [6] = '{
		'{64'h0, 64'h0, 1'b0, 1'b1, 19'd0},
		'{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, 1'b1, 19'd32640},
		'{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 19'd32640},
		'{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, 1'b0, 19'd0},
		'{64'h00FF_00FF_00FF_00FF, 64'hFF00_FF00_FF00_FF00, 1'b0, 1'b0, 19'd0},
		'{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b1, 1'b0, 19'd0}
	};

	satd_hadamard4x4_32x8_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0d: %s", cycles, msg);
		errors++;
	endtask

	function automatic int iabs(input int v);
		return v < 0 ? -v : v;
	endfunction

	// Advance the block model by one pixel row pair; return 1 when the block closes
	function automatic bit accumulate_satd(input logic [PIX_IN_W-1:0] a,
			input logic [PIX_IN_W-1:0] b, output logic [SATD_W-1:0] satd);
		int row_i, col_i, phase, p;
		int x [4];
		int h [4];
		int r0, r1, r2, r3, m0, m1;
		row_i = item_pos / ITEMS_PER_ROW;
		col_i = item_pos % ITEMS_PER_ROW;
		phase = row_i % 4;
		satd = '0;
		for (int g = 0; g < PIXELS_PER_ITEM_DEF / 4; g++) begin
			for (int i = 0; i < 4; i++)
				x[i] = int'(a[PIX_W*(4*g+i) +: PIX_W]) - int'(b[PIX_W*(4*g+i) +: PIX_W]);
			h[0] = (x[0] + x[1]) + (x[2] + x[3]);
			h[1] = (x[2] + x[3]) - (x[0] + x[1]);
			h[2] = (x[1] - x[0]) + (x[3] - x[2]);
			h[3] = (x[3] - x[2]) - (x[1] - x[0]);
			for (int k = 0; k < 4; k++) begin
				p = col_i * PIXELS_PER_ITEM_DEF + 4 * g + k;
				if (phase < 3) begin
					quad_rows[phase * BLOCK_WIDTH_DEF + p] = h[k][COEF_W-1:0];
				end else begin
					// Column transform with the max trick on the last stage
					r0 = quad_rows[p];
					r1 = quad_rows[BLOCK_WIDTH_DEF + p];
					r2 = quad_rows[2 * BLOCK_WIDTH_DEF + p];
					r3 = h[k];
					m0 = iabs(r0 + r1) > iabs(r2 + r3) ? iabs(r0 + r1) : iabs(r2 + r3);
					m1 = iabs(r0 - r1) > iabs(r2 - r3) ? iabs(r0 - r1) : iabs(r2 - r3);
					half_satd_sum = half_satd_sum + SUM_W'(m0 + m1);
				end
			end
		end
		if (item_pos + 1 >= ITEMS_PER_BLOCK) begin
			satd = half_satd_sum[SATD_W-1:0];
			half_satd_sum = '0;
			item_pos = 0;
			return 1'b1;
		end
		item_pos++;
		return 1'b0;
	endfunction

	// Send one request after a random gap (none if no_gaps); queue the block total when it closes
	task automatic send_pixels(input logic [PIX_IN_W-1:0] a, input logic [PIX_IN_W-1:0] b,
			input bit no_gaps, input bit use_known, input logic [SATD_W-1:0] known);
		int gap;
		logic [SATD_W-1:0] predicted;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b, a};
		do @(posedge clk); while (!s_axis_tready);
		if (accumulate_satd(a, b, predicted))
			satd_due.push_back(use_known ? known : predicted);
	endtask

	function automatic void draw_pixels(input pix_style_t style,
			output logic [PIX_IN_W-1:0] a, output logic [PIX_IN_W-1:0] b);
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case (style)
			PIX_NEAR: begin
				for (int i = 0; i < IN_LANES; i++)
					a[PIX_W*i +: PIX_W] = b[PIX_W*i +: PIX_W] ^ PIX_W'($urandom_range(0, 7));
			end
			PIX_EXTREME: begin
				for (int i = 0; i < IN_LANES; i++) begin
					a[PIX_W*i +: PIX_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					b[PIX_W*i +: PIX_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				end
			end
			default: ;
		endcase
	endfunction

	// Stimulus
	initial begin
		logic [PIX_IN_W-1:0] a, b;
		int row_i, pick;
		bit burst;
		pix_style_t style;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		half_satd_sum = '0;
		item_pos      = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed blocks
		foreach (block_patterns[n]) begin
			for (int i = 0; i < ITEMS_PER_BLOCK; i++) begin
				row_i = i / ITEMS_PER_ROW;
				a = block_patterns[n].a;
				b = block_patterns[n].b;
				if (block_patterns[n].swap_odd_rows && row_i % 2 == 1) begin
					a = block_patterns[n].b;
					b = block_patterns[n].a;
				end
				send_pixels(a, b, n == 0, block_patterns[n].known, block_patterns[n].satd);
			end
		end

		// Random blocks, some sent back to back
		for (int n = 0; n < RANDOM_BLOCKS; n++) begin
			burst = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < ITEMS_PER_BLOCK; i++) begin
				pick = $urandom_range(0, 9);
				style = pick < 5 ? PIX_RANDOM : (pick < 8 ? PIX_NEAR : PIX_EXTREME);
				draw_pixels(style, a, b);
				send_pixels(a, b, burst, 1'b0, '0);
			end
			// After block PAUSE_BLOCK, hold input until every pending total has come out
			if (n == PAUSE_BLOCK) begin
				s_axis_tvalid <= 1'b0;
				while (satd_due.size() != 0) @(posedge clk);
				@(posedge clk);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (satd_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Result side: random stall before each result, some with none
	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	// Compare each accepted total with the oldest one due
	always @(posedge clk) begin
		logic [SATD_W-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (satd_due.size() == 0) begin
				report_mismatch($sformatf("unexpected satd %0d", m_axis_tdata[SATD_W-1:0]));
			end else begin
				want = satd_due.pop_front();
				if (m_axis_tdata[SATD_W-1:0] !== want)
					report_mismatch($sformatf("satd %0d, want %0d",
						m_axis_tdata[SATD_W-1:0], want));
			end
		end
	end

	// Drop the run if it hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
